// File: sv/bkvt_pkg.sv
// ----------------------------------------------------------------------------
// bkvt_pkg
// Types and constants shared by the bounded key/value table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bkvt_pkg;

    localparam int CNT_W = 5;     // width of count, capacity and entries_used
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd10;

    // command codes
    localparam logic [1:0] CMD_HAS = 2'd0;
    localparam logic [1:0] CMD_PUT = 2'd1;
    localparam logic [1:0] CMD_GET = 2'd2;

    // request word
    typedef struct packed {
        logic [1:0]              command;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] new_value;
    } req_t;

    // result word
    typedef struct packed {
        logic                    success;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        entries_used;
    } rsp_t;

    // search token walking down the cell chain
    typedef struct packed {
        logic             vld;
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             hit;
        logic [VAL_W-1:0] rdval;
    } tok_t;

    // write broadcast to the cells
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } wr_t;

endpackage

`default_nettype wire

// File: sv/bkvt_cell.sv
// ----------------------------------------------------------------------------
// bkvt_cell
// One table entry: holds a key/value pair, compares the passing token's key
// and hands the updated token, registered, on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bkvt_cell
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          live,    // entry below the fill count
    input  wire logic          we,      // write this entry
    input  wire bkvt_pkg::wr_t wdata,
    input  wire bkvt_pkg::tok_t tok_in,
    output bkvt_pkg::tok_t     tok_out
);

    logic [bkvt_pkg::KEY_W-1:0] key_reg;
    logic [bkvt_pkg::VAL_W-1:0] val_reg;
    logic                       vld_reg;
    bkvt_pkg::tok_t             tok_reg;
    bkvt_pkg::tok_t             tok_next;
    logic                       match;

    assign match = live && (key_reg == tok_in.key);

    always_comb
    begin
        tok_next = tok_in;
        if (match && !tok_in.hit)
        begin
            tok_next.hit   = 1'b1;
            tok_next.rdval = val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= tok_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (we)
        begin
            key_reg <= wdata.key;
            val_reg <= wdata.value;
        end
    end

    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = vld_reg;
    end

endmodule

`default_nettype wire

// File: sv/bounded_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// bounded_key_value_table_unit
// Fixed-capacity associative table of signed 32-bit key/value pairs with
// has, put and get commands, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// The search token enters the DEPTH-cell chain on an accepted start and moves
//   one cell per cycle to its end, where the result is registered with done.
// One word at a time: a new start is taken once busy drops (as done rises).
// done is high for one cycle and rsp holds until the next result; the receiver cannot stall them.
// Reset: entry count cleared, capacity set to 10, chain emptied; entry
//   storage is not cleared (only entries below the count are compared).
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_key_value_table_unit
#(
    parameter int DEPTH = 16          // built entries, 1..256
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request side
    input  wire logic                          start,
    output logic                               busy,
    input  wire bkvt_pkg::req_t                req,
    // configuration: capacity register
    input  wire logic                          cfg_we,
    input  wire logic [bkvt_pkg::CNT_W-1:0]    cfg_data,
    // result side
    output logic                               done,
    output bkvt_pkg::rsp_t                     rsp
);

    // Count is 5 bits wide, so no more than 31 entries can ever be in use,
    // whatever DEPTH is built.
    localparam int CNT_MAX = (1 << bkvt_pkg::CNT_W) - 1;
    localparam int LIM_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;

    logic [bkvt_pkg::CNT_W-1:0] cap_reg;
    logic [bkvt_pkg::CNT_W-1:0] count_reg;
    logic [bkvt_pkg::CNT_W-1:0] count_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    bkvt_pkg::rsp_t             rsp_reg;
    bkvt_pkg::rsp_t             rsp_next;

    logic                       accept;
    logic [bkvt_pkg::CNT_W-1:0] limit;
    logic                       commit;
    bkvt_pkg::tok_t             fin;
    bkvt_pkg::wr_t              wdata;

    bkvt_pkg::tok_t             chain [DEPTH+1];
    logic [DEPTH-1:0]           live;
    logic [DEPTH-1:0]           we;
    logic [DEPTH-1:0]           tok_vld;

    assign accept = start && !busy_reg;

    // Token enters cell 0 straight from the request port on accept.
    always_comb
    begin
        chain[0].vld   = accept;
        chain[0].cmd   = req.command;
        chain[0].key   = req.lookup_key;
        chain[0].value = req.new_value;
        chain[0].hit   = 1'b0;
        chain[0].rdval = '0;
    end

    // ---- cell chain ---------------------------------------------------------
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            // entry i is live once the count has passed it
            assign live[i]    = (32'(count_reg) > 32'(i));
            // a committed put lands in the first free entry
            assign we[i]      = commit && (32'(count_reg) == 32'(i));
            assign tok_vld[i] = chain[i+1].vld;

            bkvt_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .live    (live[i]),
                .we      (we[i]),
                .wdata   (wdata),
                .tok_in  (chain[i]),
                .tok_out (chain[i+1])
            );
        end
    endgenerate

    // ---- finalize at the end of the chain ---------------------------------
    assign fin = chain[DEPTH];

    // effective limit: capacity saturated at the built depth, or at 31 if lower
    assign limit = (32'(cap_reg) < LIM_MAX) ? cap_reg : bkvt_pkg::CNT_W'(LIM_MAX);

    // put stores only on a miss with room left
    assign commit = fin.vld && (fin.cmd == bkvt_pkg::CMD_PUT) && !fin.hit
                    && (count_reg < limit);

    assign wdata.key   = fin.key;
    assign wdata.value = fin.value;

    assign count_next = commit ? (count_reg + bkvt_pkg::CNT_W'(1)) : count_reg;

    always_comb
    begin
        rsp_next.success      = 1'b0;
        rsp_next.read_value   = '0;
        rsp_next.entries_used = count_next;
        case (fin.cmd)
            bkvt_pkg::CMD_HAS:
            begin
                rsp_next.success = fin.hit;
            end
            bkvt_pkg::CMD_PUT:
            begin
                rsp_next.success = commit;
            end
            bkvt_pkg::CMD_GET:
            begin
                // rdval stays zero on a miss
                rsp_next.success    = fin.hit;
                rsp_next.read_value = fin.rdval;
            end
            default:
            begin
                // unused code: no effect, success and read value zero
                rsp_next.success = 1'b0;
            end
        endcase
    end

    // one item in flight; busy drops as its result is registered
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (fin.vld)
        begin
            busy_next = 1'b0;
        end
    end

    // ---- control registers --------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= bkvt_pkg::CAP_RESET;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= fin.vld;
        end
    end

    // result word, no reset needed
    always_ff @(posedge clk)
    begin
        if (fin.vld)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // ---- assertions ---------------------------------------------------------
`ifndef NO_ASSERTIONS
    // the token reaches the end of the chain at a fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(DEPTH+1) done)
        else $error("done did not follow an accepted start at DEPTH+1");

    // only one search token in the chain at any time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one token in the cell chain");

    // count grows by one at most and never past the built limit
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg))
            |-> (count_reg == $past(count_reg) + bkvt_pkg::CNT_W'(1)))
        else $error("entry count changed by other than one");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) <= LIM_MAX))
        else $error("entry count above built depth");
`endif

endmodule

`default_nettype wire
